>>> rtl/core/d2i_pkg.sv
// ----------------------------------------------------------------------------
// d2i_pkg: shared constants and types for the double to int32 converter
// Holds status bit masks, rounding mode codes and the result tag.
// ----------------------------------------------------------------------------
package d2i_pkg;

	localparam logic [31:0] ST_FEX    = 32'h4000_0000;
	localparam logic [31:0] ST_VX     = 32'h2000_0000;
	localparam logic [31:0] ST_VXSNAN = 32'h0100_0000;
	localparam logic [31:0] ST_FR     = 32'h0004_0000;
	localparam logic [31:0] ST_FI     = 32'h0002_0000;
	localparam logic [31:0] ST_VXCVI  = 32'h0000_0100;
	localparam logic [31:0] UPPER_TAG = 32'hFFF8_0000;
	localparam logic [31:0] WORD_NEG  = 32'h8000_0000;
	localparam logic [31:0] WORD_POS  = 32'h7FFF_FFFF;

	localparam logic [1:0] RM_NEAREST = 2'd0;
	localparam logic [1:0] RM_ZERO    = 2'd1;
	localparam logic [1:0] RM_PINF    = 2'd2;
	localparam logic [1:0] RM_MINF    = 2'd3;

	localparam logic CFG_ROUND_MODE = 1'b0;
	localparam logic CFG_INV_ENABLE = 1'b1;

	// per-item outcome of the conversion datapath
	typedef struct packed {
		logic [31:0] word;
		logic        invalid;
		logic        snan;
	} conv_t;

endpackage

>>> rtl/core/double_to_int32_convert_core.sv
// ----------------------------------------------------------------------------
// double_to_int32_convert_core: double to int32 conversion unit
// An item loads the input register when accepted and moves to the result
// register, raising out_valid, once the output is not stalled. Throughput:
// one item per cycle while the output is not stalled, set by the single-pass
// convert datapath between the two registers; a stalled output backs up two
// items. Reset clears valids, status bits and configuration registers at once.
// ----------------------------------------------------------------------------
module double_to_int32_convert_core import d2i_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [63:0] operand_bits,
	input  logic        record_cr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] result_bits,
	output logic        write_result,
	output logic        raise_exception,
	output logic [31:0] status_word,
	output logic [3:0]  cr1_bits,
	output logic        cr1_valid
);

	logic [1:0]  round_mode_q;
	logic        inv_en_q;
	logic [31:0] status_q;
	logic        v_s1;
	logic        opc_s1;
	logic [63:0] op_s1;
	logic        rec_s1;
	logic        adv_s1;
	logic        adv_s2;
	conv_t       conv;
	logic [31:0] st_next;
	logic [31:0] sw_next;

	// advance a stage when it is empty or its item moves on
	assign cfg_ready = 1'b1;
	assign adv_s2    = !out_valid || !out_stall;
	assign adv_s1    = !v_s1 || adv_s2;
	assign in_stall  = !adv_s1;

	d2i_convert u_conv (
		.operand (op_s1),
		.mode    (opc_s1 ? RM_ZERO : round_mode_q),
		.conv    (conv)
	);

	// compute sticky status update
	always_comb begin
		st_next = status_q;
		if (conv.invalid) begin
			st_next = (st_next & ~(ST_FR | ST_FI)) | ST_VXCVI | ST_VX;
			if (conv.snan) st_next = st_next | ST_VXSNAN;
			if (inv_en_q)  st_next = st_next | ST_FEX;
		end
		sw_next = st_next | {24'd0, inv_en_q, 5'd0, round_mode_q};
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_mode_q <= RM_NEAREST;
			inv_en_q     <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROUND_MODE: round_mode_q <= cfg_data;
				CFG_INV_ENABLE: inv_en_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			opc_s1 <= opcode;
			op_s1  <= operand_bits;
			rec_s1 <= record_cr;
		end
	end

	// result stage and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			status_q  <= 32'd0;
		end else if (adv_s2) begin
			out_valid <= v_s1;
			if (v_s1) status_q <= st_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			if (conv.invalid && inv_en_q) begin
				result_bits     <= 64'd0;
				write_result    <= 1'b0;
				raise_exception <= 1'b1;
			end else begin
				result_bits     <= {UPPER_TAG, conv.word};
				write_result    <= 1'b1;
				raise_exception <= 1'b0;
			end
			status_word <= sw_next;
			cr1_bits    <= rec_s1 ? sw_next[31:28] : 4'd0;
			cr1_valid   <= rec_s1;
		end
	end

`ifndef NO_ASSERTIONS
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (write_result != raise_exception))
		else $error("write and raise both or neither set");
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && raise_exception) |-> status_word[30])
		else $error("exception without FEX");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(result_bits))
		else $error("stalled result changed");
`endif

endmodule

>>> rtl/core/d2i_convert.sv
// ----------------------------------------------------------------------------
// d2i_convert: combinational double to int32 conversion
// Aligns the significand, rounds by mode and checks the rounded range.
// ----------------------------------------------------------------------------
module d2i_convert import d2i_pkg::*; (
	input  logic [63:0] operand,
	input  logic [1:0]  mode,
	output conv_t       conv
);

	logic        sign;
	logic [10:0] bexp;
	logic [51:0] frac;
	logic [52:0] m;
	logic [5:0]  sh;
	logic        tiny;
	logic [32:0] mag;
	logic [52:0] rem;
	logic [52:0] half;
	logic        up;
	logic [33:0] mag_r;

	always_comb begin
		sign = operand[63];
		bexp = operand[62:52];
		frac = operand[51:0];
		m    = {bexp != 11'd0, frac};
		// shift = 1075 - eeff; valid shifts range 21..53 matter, beyond is below one half
		tiny = (bexp < 11'd1022);
		sh   = tiny ? 6'd0 : 6'(11'd1075 - ((bexp == 11'd0) ? 11'd1 : bexp));
		mag  = 33'd0;
		rem  = m;
		half = 53'd0;
		if (!tiny && bexp < 11'd1055) begin
			mag  = 33'(m >> sh);
			rem  = m & ((53'd1 << sh) - 53'd1);
			half = 53'd1 << (sh - 6'd1);
		end
		// pick the rounding increment
		case (mode)
			RM_NEAREST: up = (half != 53'd0) && ((rem > half) || (rem == half && mag[0]));
			RM_PINF:    up = (rem != 53'd0) && !sign;
			RM_MINF:    up = (rem != 53'd0) && sign;
			default:    up = 1'b0;
		endcase
		mag_r = {1'b0, mag} + {33'd0, up};

		conv.invalid = 1'b0;
		conv.snan    = 1'b0;
		if (bexp == 11'h7FF && frac != 52'd0) begin
			conv.invalid = 1'b1;
			conv.snan    = !operand[51];
			conv.word    = WORD_NEG;
		end else if (bexp >= 11'd1055) begin
			conv.invalid = 1'b1;
			conv.word    = sign ? WORD_NEG : WORD_POS;
		end else if (!sign && mag_r > 34'h0_7FFF_FFFF) begin
			conv.invalid = 1'b1;
			conv.word    = WORD_POS;
		end else if (sign && mag_r > 34'h0_8000_0000) begin
			conv.invalid = 1'b1;
			conv.word    = WORD_NEG;
		end else begin
			conv.word = sign ? (32'd0 - mag_r[31:0]) : mag_r[31:0];
		end
	end

endmodule
